[rtl/bspq_pkg.sv]
// Shared types and constants of the bounded sorted priority queue.
// Used by the top level and by its port checker; depends on nothing.
package bspq_pkg;

    // field widths
    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int ITEM_W   = 31;
    localparam int SRC_W    = 8;
    localparam int CNT_W    = 5;
    localparam int FILL_W   = 5;
    localparam int CAP_W    = 5;
    localparam int FIDX_W   = 4;

    // stream widths, padded to whole bytes
    localparam int IN_FIELDS_W  = KEY_W + ITEM_W + SRC_W + CNT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + KEY_W + ITEM_W + SRC_W + 1 + FIDX_W + 1 + FILL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // result field offsets in m_axis_tdata
    localparam int OUT_HV_LSB    = 0;
    localparam int OUT_FOUND_LSB = 1 + KEY_W + ITEM_W + SRC_W;
    localparam int OUT_FIDX_LSB  = OUT_FOUND_LSB + 1;
    localparam int OUT_ACC_LSB   = OUT_FIDX_LSB + FIDX_W;
    localparam int OUT_OCC_LSB   = OUT_ACC_LSB + 1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR     = 3'd0,
        CMD_INSERT    = 3'd1,
        CMD_REMOVE    = 3'd2,
        CMD_READ_HEAD = 3'd3,
        CMD_FIND_ITEM = 3'd4,
        CMD_FIND_SRC  = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ITEM_W-1:0] item;
        logic [SRC_W-1:0]  src;
    } entry_t;

endpackage

[rtl/bounded_sorted_priority_queue.sv]
// Top level of the bounded sorted priority queue: command sequencer and entry memory.
// Depends on bspq_pkg.
//
// Usage
//   s_axis: one command per transaction. tuser carries the command code,
//   tdata the operands. m_axis: exactly one result transaction per command.
//   cfg_wr_en / cfg_wr_data write the capacity register; write only while
//   the queue is idle.
// Storage
//   Entries live in one synchronous memory (one write, one read, registered
//   read data) organized as a ring: logical position 0 (largest distance)
//   sits at a base pointer, so dropping the largest entry only moves the
//   base, and removing the smallest ones only lowers the fill level.
// Sequence (from accept to the edge that raises m_axis_tvalid; s_axis_tready
// rises again with that edge)
//   clear, remove, read head, unused codes: S_EXEC, then S_RESP reads the head.
//   find: S_EXEC, S_FIND compares entries from the head end up to the match, S_RESP.
//   insert: S_EXEC, S_INS, S_SHIFT compares entries while moving them toward the
//   tail, S_PUT, S_RESP; when full, S_CHK first rejects or drops the largest entry.
//   Each compared entry takes one memory read.
// Reset and stall
//   Reset empties the queue and sets the capacity to 16. A result waits in
//   the output register while m_axis_tready is low; the next command is
//   accepted meanwhile and finishes up to the point of delivering its result.
module bounded_sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // tdata: distance[31:0], item_id[62:32], source_id[70:63], count[75:71]
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bspq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: command[2:0]
    input  logic [bspq_pkg::CMD_W-1:0]        s_axis_tuser,
    // tdata: head_valid[0], head_distance[32:1], head_item[63:33],
    //        head_source[71:64], found[72], found_index[76:73],
    //        accepted[77], occupancy[82:78]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bspq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              cfg_wr_en,
    input  logic [bspq_pkg::CAP_W-1:0]        cfg_wr_data
);
    import bspq_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RING = 2 ** AW;
    localparam logic [FILL_W-1:0] CAP_MAX = FILL_W'((DEPTH > 31) ? 31 : DEPTH);
    localparam int OUT_PAD = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHK,
        S_INS,
        S_SHIFT,
        S_PUT,
        S_FIND,
        S_RESP
    } state_t;

    // S_HEAD folded into a flag to keep the state count at eight
    state_t                   state_reg, state_next;
    logic                     head_rd_reg, head_rd_next;
    logic [AW-1:0]            base_reg, base_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [CAP_W-1:0]         cap_reg;
    logic [CMD_W-1:0]         cmd_reg, cmd_next;
    logic [KEY_W-1:0]         dist_reg, dist_next;
    logic [ITEM_W-1:0]        item_reg, item_next;
    logic [SRC_W-1:0]         src_reg, src_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [FILL_W-1:0]        idx_reg, idx_next;
    logic [FILL_W-1:0]        put_reg, put_next;
    logic                     found_reg, found_next;
    logic [FIDX_W-1:0]        fidx_reg, fidx_next;
    logic                     acc_reg, acc_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // entry memory and its port controls
    entry_t                   entry_mem [RING];
    entry_t                   rd_data_reg;
    logic                     rd_en;
    logic [FILL_W-1:0]        rd_pos;
    logic                     wr_en;
    logic [FILL_W-1:0]        wr_pos;
    entry_t                   wr_data;
    logic [AW-1:0]            rd_addr, wr_addr;

    logic [FILL_W-1:0]        eff_cap;
    logic                     head_valid;
    entry_t                   new_entry;
    logic                     key_match;

    // effective capacity: zero acts as one, clamp at the memory depth
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = FILL_W'(1);
        end else if (FILL_W'(cap_reg) > CAP_MAX) begin
            eff_cap = CAP_MAX;
        end else begin
            eff_cap = FILL_W'(cap_reg);
        end
    end

    assign rd_addr    = base_reg + AW'(rd_pos);
    assign wr_addr    = base_reg + AW'(wr_pos);
    assign new_entry  = '{key: dist_reg, item: item_reg, src: src_reg};
    assign head_valid = (fill_reg != '0);
    assign key_match  = (cmd_reg == CMD_FIND_ITEM) ? (rd_data_reg.item == item_reg)
                                                   : (rd_data_reg.src == src_reg);

    // memory: one write and one registered read per cycle; the sequencer
    // never reads and writes the same position in one cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    // sequencer next-state logic
    always_comb begin
        state_next    = state_reg;
        head_rd_next  = head_rd_reg;
        base_next     = base_reg;
        fill_next     = fill_reg;
        cmd_next      = cmd_reg;
        dist_next     = dist_reg;
        item_next     = item_reg;
        src_next      = src_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        put_next      = put_reg;
        found_next    = found_reg;
        fidx_next     = fidx_reg;
        acc_next      = acc_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        rd_en         = 1'b0;
        rd_pos        = '0;
        wr_en         = 1'b0;
        wr_pos        = '0;
        wr_data       = rd_data_reg;

        // result taken by the receiver
        if (m_tvalid_reg && m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd_next   = s_axis_tuser;
                    dist_next  = s_axis_tdata[KEY_W-1:0];
                    item_next  = s_axis_tdata[KEY_W +: ITEM_W];
                    src_next   = s_axis_tdata[KEY_W+ITEM_W +: SRC_W];
                    cnt_next   = s_axis_tdata[KEY_W+ITEM_W+SRC_W +: CNT_W];
                    found_next = 1'b0;
                    fidx_next  = '0;
                    acc_next   = 1'b0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                head_rd_next = 1'b1;
                state_next   = S_RESP;
                unique case (cmd_reg)
                    CMD_CLEAR: begin
                        fill_next = '0;
                    end
                    CMD_INSERT: begin
                        head_rd_next = 1'b0;
                        if (fill_reg >= eff_cap) begin
                            if (fill_reg == '0) begin
                                head_rd_next = 1'b1;
                            end else begin
                                // fetch the largest entry for the full check
                                rd_en      = 1'b1;
                                rd_pos     = '0;
                                state_next = S_CHK;
                            end
                        end else begin
                            state_next = S_INS;
                        end
                    end
                    CMD_REMOVE: begin
                        fill_next = (FILL_W'(cnt_reg) >= fill_reg) ? '0
                                                                 : fill_reg - FILL_W'(cnt_reg);
                    end
                    CMD_FIND_ITEM, CMD_FIND_SRC: begin
                        if (fill_reg != '0) begin
                            // scan from the head end toward position 0
                            head_rd_next = 1'b0;
                            rd_en        = 1'b1;
                            rd_pos       = fill_reg - FILL_W'(1);
                            idx_next     = fill_reg - FILL_W'(1);
                            state_next   = S_FIND;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_CHK: begin
                if (dist_reg >= rd_data_reg.key) begin
                    head_rd_next = 1'b1;
                    state_next   = S_RESP;
                end else begin
                    // drop the largest entry
                    base_next  = base_reg + AW'(1);
                    fill_next  = fill_reg - FILL_W'(1);
                    state_next = S_INS;
                end
            end

            S_INS: begin
                if (fill_reg == '0) begin
                    put_next   = '0;
                    state_next = S_PUT;
                end else begin
                    rd_en      = 1'b1;
                    rd_pos     = fill_reg - FILL_W'(1);
                    idx_next   = fill_reg - FILL_W'(1);
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT: begin
                if (rd_data_reg.key > dist_reg) begin
                    put_next   = idx_reg + FILL_W'(1);
                    state_next = S_PUT;
                end else begin
                    // move the entry one place toward the tail
                    wr_en   = 1'b1;
                    wr_pos  = idx_reg + FILL_W'(1);
                    wr_data = rd_data_reg;
                    if (idx_reg == '0) begin
                        put_next   = '0;
                        state_next = S_PUT;
                    end else begin
                        rd_en    = 1'b1;
                        rd_pos   = idx_reg - FILL_W'(1);
                        idx_next = idx_reg - FILL_W'(1);
                    end
                end
            end

            S_PUT: begin
                wr_en        = 1'b1;
                wr_pos       = put_reg;
                wr_data      = new_entry;
                fill_next    = fill_reg + FILL_W'(1);
                acc_next     = 1'b1;
                head_rd_next = 1'b1;
                state_next   = S_RESP;
            end

            S_FIND: begin
                if (key_match) begin
                    found_next   = 1'b1;
                    fidx_next    = idx_reg[FIDX_W-1:0];
                    head_rd_next = 1'b1;
                    state_next   = S_RESP;
                end else if (idx_reg == '0) begin
                    head_rd_next = 1'b1;
                    state_next   = S_RESP;
                end else begin
                    rd_en    = 1'b1;
                    rd_pos   = idx_reg - FILL_W'(1);
                    idx_next = idx_reg - FILL_W'(1);
                end
            end

            S_RESP: begin
                if (head_rd_reg) begin
                    // fetch the head entry; the write of S_PUT has landed
                    head_rd_next = 1'b0;
                    rd_en        = head_valid;
                    rd_pos       = fill_reg - FILL_W'(1);
                end else if (!m_tvalid_reg || m_axis_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {
                        {OUT_PAD{1'b0}},
                        fill_reg,
                        acc_reg,
                        fidx_reg,
                        found_reg,
                        head_valid ? rd_data_reg.src  : {SRC_W{1'b0}},
                        head_valid ? rd_data_reg.item : {ITEM_W{1'b0}},
                        head_valid ? rd_data_reg.key  : {KEY_W{1'b0}},
                        head_valid
                    };
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, control and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_rd_reg  <= 1'b0;
            base_reg     <= '0;
            fill_reg     <= '0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_rd_reg  <= head_rd_next;
            base_reg     <= base_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
        cmd_reg     <= cmd_next;
        dist_reg    <= dist_next;
        item_reg    <= item_next;
        src_reg     <= src_next;
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
        put_reg     <= put_next;
        found_reg   <= found_next;
        fidx_reg    <= fidx_next;
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

[rtl/bspq_checker.sv]
// Port-level checker for the bounded sorted priority queue, bound to the top level.
// Depends on bspq_pkg and bounded_sorted_priority_queue.
module bspq_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [bspq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import bspq_pkg::*;

    logic                hv;
    logic                found;
    logic                acc;
    logic [FIDX_W-1:0]   fidx;
    logic [FILL_W-1:0]   occ;

    assign hv    = m_axis_tdata[OUT_HV_LSB];
    assign found = m_axis_tdata[OUT_FOUND_LSB];
    assign acc   = m_axis_tdata[OUT_ACC_LSB];
    assign fidx  = m_axis_tdata[OUT_FIDX_LSB +: FIDX_W];
    assign occ   = m_axis_tdata[OUT_OCC_LSB +: FILL_W];

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // head valid tracks a nonzero occupancy
    a_head_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (hv == (occ != '0)))
        else $error("head_valid disagrees with occupancy");

    // an accepted insert leaves the queue nonempty
    a_acc_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && acc |-> hv)
        else $error("accepted insert with empty queue");

    // a match lies inside the stored range, no match reports index zero
    a_found_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (found ? (FILL_W'(fidx) < occ) : (fidx == '0)))
        else $error("found_index out of range");

    // nothing comes out in the cycle after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind bounded_sorted_priority_queue bspq_checker u_bspq_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for bounded_sorted_priority_queue: random and directed
// command streams checked against a sorted-array predictor. Depends on bspq_pkg.
module testbench;
    import bspq_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int CALM_TAIL   = 80;
    localparam int RANDOM_CMDS = 900;

    // opcodes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {JOB_CMD, JOB_CFG, JOB_DRAIN} job_kind_t;

    typedef struct {
        job_kind_t         kind;
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic [ITEM_W-1:0] item;
        logic [SRC_W-1:0]  src;
        logic [CNT_W-1:0]  cnt;
        logic [CAP_W-1:0]  cap;
    } job_t;

    // operand layout of s_axis_tdata, highest field first
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [SRC_W-1:0]  src;
        logic [ITEM_W-1:0] item;
        logic [KEY_W-1:0]  key;
    } operands_t;

    // result layout of m_axis_tdata, highest field first
    typedef struct packed {
        logic [FILL_W-1:0] occupancy;
        logic              accepted;
        logic [FIDX_W-1:0] found_index;
        logic              found;
        logic [SRC_W-1:0]  head_source;
        logic [ITEM_W-1:0] head_item;
        logic [KEY_W-1:0]  head_key;
        logic              head_valid;
    } report_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]       cfg_wr_data = '0;

    bounded_sorted_priority_queue #(.DEPTH(QDEPTH)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // stimulus backlog and results still owed by the block
    job_t    cmd_backlog[$];
    report_t expected_reports[$];
    int      total_cmds = 0;
    int      sent_count = 0;
    int      recv_count = 0;
    int      mismatches = 0;
    int      cycle_count;

    // ---------------------------------------------------------------
    // Predictor: sorted array, index 0 holds the largest key
    // ---------------------------------------------------------------
    logic [KEY_W-1:0]  pq_key  [QDEPTH];
    logic [ITEM_W-1:0] pq_item [QDEPTH];
    logic [SRC_W-1:0]  pq_src  [QDEPTH];
    int unsigned       pq_fill = 0;
    logic [CAP_W-1:0]  cap_setting = CAP_RESET;

    function automatic int unsigned cap_limit();
        int unsigned c;
        c = cap_setting;
        if (c < 1) c = 1;
        if (c > QDEPTH) c = QDEPTH;
        return c;
    endfunction

    function automatic logic pq_insert(logic [KEY_W-1:0] key, logic [ITEM_W-1:0] item,
                                       logic [SRC_W-1:0] src);
        int unsigned pos;
        pos = 0;
        // full: reject unless smaller than the largest, else drop the largest
        if (pq_fill >= cap_limit()) begin
            if (pq_fill == 0 || key >= pq_key[0]) return 1'b0;
            for (int i = 0; i + 1 < pq_fill; i++) begin
                pq_key[i]  = pq_key[i+1];
                pq_item[i] = pq_item[i+1];
                pq_src[i]  = pq_src[i+1];
            end
            pq_fill--;
        end
        if (pq_fill >= QDEPTH) return 1'b0;
        // new entry lands on the large side of equal keys
        for (int i = 0; i < pq_fill; i++)
            if (pq_key[i] > key) pos = i + 1;
        for (int i = pq_fill; i > pos; i--) begin
            pq_key[i]  = pq_key[i-1];
            pq_item[i] = pq_item[i-1];
            pq_src[i]  = pq_src[i-1];
        end
        pq_key[pos]  = key;
        pq_item[pos] = item;
        pq_src[pos]  = src;
        pq_fill++;
        return 1'b1;
    endfunction

    function automatic report_t queue_outcome(job_t j);
        report_t r;
        r = '0;
        case (j.cmd)
            CMD_CLEAR:  pq_fill = 0;
            CMD_INSERT: r.accepted = pq_insert(j.key, j.item, j.src);
            CMD_REMOVE: pq_fill = (j.cnt >= pq_fill) ? 0 : pq_fill - j.cnt;
            CMD_FIND_ITEM: begin
                for (int i = 0; i < pq_fill; i++)
                    if (pq_item[i] == j.item) begin
                        r.found       = 1'b1;
                        r.found_index = FIDX_W'(i);
                    end
            end
            CMD_FIND_SRC: begin
                for (int i = 0; i < pq_fill; i++)
                    if (pq_src[i] == j.src) begin
                        r.found       = 1'b1;
                        r.found_index = FIDX_W'(i);
                    end
            end
            default: ;
        endcase
        if (pq_fill > 0) begin
            r.head_valid  = 1'b1;
            r.head_key    = pq_key[pq_fill-1];
            r.head_item   = pq_item[pq_fill-1];
            r.head_source = pq_src[pq_fill-1];
        end
        r.occupancy = FILL_W'(pq_fill);
        return r;
    endfunction

    function automatic string fmt_report(report_t r);
        return $sformatf("hv=%0d key=%h item=%h src=%h found=%0d idx=%0d acc=%0d occ=%0d",
                         r.head_valid, r.head_key, r.head_item, r.head_source, r.found,
                         r.found_index, r.accepted, r.occupancy);
    endfunction

    // ---------------------------------------------------------------
    // Backlog builders
    // ---------------------------------------------------------------
    task automatic add_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                           logic [ITEM_W-1:0] item, logic [SRC_W-1:0] src,
                           logic [CNT_W-1:0] cnt);
        job_t j;
        j.kind = JOB_CMD;
        j.cmd  = cmd;
        j.key  = key;
        j.item = item;
        j.src  = src;
        j.cnt  = cnt;
        j.cap  = '0;
        cmd_backlog.push_back(j);
        total_cmds++;
    endtask

    task automatic add_marker(job_kind_t kind, logic [CAP_W-1:0] cap);
        job_t j;
        j.kind = kind;
        j.cmd  = '0;
        j.key  = '0;
        j.item = '0;
        j.src  = '0;
        j.cnt  = '0;
        j.cap  = cap;
        cmd_backlog.push_back(j);
    endtask

    // keys from a small pool make ties and full-queue replacement common
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return KEY_W'($urandom_range(0, 24));
        if (r < 8) return KEY_W'($urandom);
        if (r == 8) return '0;
        return '1;
    endfunction

    function automatic logic [ITEM_W-1:0] pick_item();
        if ($urandom_range(0, 3) == 0) return ITEM_W'($urandom);
        return ITEM_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [SRC_W-1:0] pick_src();
        if ($urandom_range(0, 3) == 0) return SRC_W'($urandom);
        return SRC_W'($urandom_range(0, 7));
    endfunction

    function automatic logic [CNT_W-1:0] pick_cnt();
        if ($urandom_range(0, 4) == 0) return CNT_W'($urandom_range(0, 31));
        return CNT_W'($urandom_range(1, 2));
    endfunction

    task automatic add_random_cmd();
        int               r;
        logic [CMD_W-1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 45)      cmd = CMD_INSERT;
        else if (r < 55) cmd = CMD_REMOVE;
        else if (r < 65) cmd = CMD_READ_HEAD;
        else if (r < 79) cmd = CMD_FIND_ITEM;
        else if (r < 93) cmd = CMD_FIND_SRC;
        else if (r < 96) cmd = CMD_CLEAR;
        else if (r < 98) cmd = CMD_SPARE_6;
        else             cmd = CMD_SPARE_7;
        add_cmd(cmd, pick_key(), pick_item(), pick_src(), pick_cnt());
    endtask

    // ---------------------------------------------------------------
    // Driver: one transaction, register write or pause per backlog entry
    // ---------------------------------------------------------------
    job_t cur_job;
    int   gap_left = 0;
    int   drv_stretch = 0;
    logic drv_idles = 1'b0;

    always @(posedge aclk) begin
        logic valid_nxt;
        logic cfg_nxt;
        job_t j;
        valid_nxt = s_axis_tvalid;
        cfg_nxt   = 1'b0;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_reports.push_back(queue_outcome(cur_job));
                sent_count++;
                valid_nxt = 1'b0;
            end
            if (!valid_nxt) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_backlog.size() > 0) begin
                    j = cmd_backlog[0];
                    case (j.kind)
                        JOB_CMD: begin
                            cur_job      = j;
                            s_axis_tdata <= IN_TDATA_W'(operands_t'{j.cnt, j.src, j.item, j.key});
                            s_axis_tuser <= j.cmd;
                            valid_nxt    = 1'b1;
                            void'(cmd_backlog.pop_front());
                            // idle bursts come in stretches, none near the end
                            if (sent_count + CALM_TAIL >= total_cmds) begin
                                gap_left = 0;
                            end else begin
                                if (drv_stretch == 0) begin
                                    drv_stretch = $urandom_range(10, 50);
                                    drv_idles   = ($urandom_range(0, 2) != 0);
                                end
                                drv_stretch--;
                                gap_left = (drv_idles && $urandom_range(0, 2) == 0) ?
                                           $urandom_range(1, 17) : 0;
                            end
                        end
                        // register writes and pauses wait for the block to go idle
                        JOB_CFG: begin
                            if (sent_count == recv_count) begin
                                cap_setting = j.cap;
                                cfg_wr_data <= j.cap;
                                cfg_nxt     = 1'b1;
                                void'(cmd_backlog.pop_front());
                            end
                        end
                        default: begin
                            if (sent_count == recv_count) void'(cmd_backlog.pop_front());
                        end
                    endcase
                end
            end
        end
        s_axis_tvalid <= valid_nxt;
        cfg_wr_en     <= cfg_nxt;
    end

    // ---------------------------------------------------------------
    // Monitor: random backpressure and in-order result check
    // ---------------------------------------------------------------
    int   stall_left = 0;
    int   mon_stretch = 0;
    logic mon_stalls = 1'b0;

    always @(posedge aclk) begin
        logic    ready_nxt;
        report_t got;
        report_t want;
        ready_nxt = m_axis_tready;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = report_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
                recv_count <= recv_count + 1;
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: %s", fmt_report(got));
                end else begin
                    want = expected_reports.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected %s", fmt_report(want));
                            $display("  actual   %s", fmt_report(got));
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                ready_nxt = 1'b0;
            end else if (recv_count + CALM_TAIL >= total_cmds) begin
                ready_nxt = 1'b1;
            end else begin
                if (mon_stretch == 0) begin
                    mon_stretch = $urandom_range(10, 60);
                    mon_stalls  = ($urandom_range(0, 2) != 0);
                end
                mon_stretch--;
                if (mon_stalls && $urandom_range(0, 3) == 0) begin
                    stall_left = $urandom_range(1, 17) - 1;
                    ready_nxt  = 1'b0;
                end else begin
                    ready_nxt = 1'b1;
                end
            end
        end
        m_axis_tready <= ready_nxt;
    end

    // ---------------------------------------------------------------
    // Watchdog
    // ---------------------------------------------------------------
    initial begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge aclk);
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus plan and end of run
    // ---------------------------------------------------------------
    initial begin : stimulus
        int              phase;
        int              burst;
        logic [CAP_W-1:0] cap;

        // empty queue: head read, zero-count remove, failed find
        add_cmd(CMD_READ_HEAD, 32'd0, 31'd0, 8'd0, 5'd1);
        add_cmd(CMD_REMOVE, 32'd5, 31'd1, 8'd1, 5'd0);
        add_cmd(CMD_FIND_ITEM, 32'd0, 31'd0, 8'd0, 5'd1);
        // capacity 0 behaves as 1: ties and larger keys rejected, smaller replaces
        add_marker(JOB_CFG, 5'd0);
        add_cmd(CMD_INSERT, 32'd100, 31'd1, 8'd1, 5'd1);
        add_cmd(CMD_INSERT, 32'd100, 31'd2, 8'd1, 5'd1);
        add_cmd(CMD_INSERT, 32'hFFFF_FFFF, 31'd2, 8'd1, 5'd1);
        add_cmd(CMD_INSERT, 32'd0, 31'h7FFF_FFFF, 8'hFF, 5'd31);
        // capacity above depth behaves as depth
        add_marker(JOB_CFG, 5'd31);
        add_cmd(CMD_INSERT, 32'hFFFF_FFFF, 31'd0, 8'd0, 5'd1);
        add_cmd(CMD_INSERT, 32'd500, 31'd3, 8'd2, 5'd1);
        add_cmd(CMD_INSERT, 32'd500, 31'd4, 8'd2, 5'd1);
        add_cmd(CMD_INSERT, 32'd500, 31'd3, 8'd9, 5'd1);
        add_cmd(CMD_FIND_ITEM, 32'd0, 31'd3, 8'd0, 5'd1);
        add_cmd(CMD_FIND_SRC, 32'd0, 31'd0, 8'hFF, 5'd1);
        add_cmd(CMD_FIND_SRC, 32'd0, 31'd0, 8'd2, 5'd1);
        add_cmd(CMD_FIND_ITEM, 32'd0, 31'h7FFF_FFFF, 8'd0, 5'd1);
        add_cmd(CMD_FIND_ITEM, 32'd0, 31'd12345, 8'd0, 5'd1);
        add_cmd(CMD_SPARE_6, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF, 5'd31);
        add_cmd(CMD_SPARE_7, 32'd7, 31'd7, 8'd7, 5'd7);
        add_cmd(CMD_REMOVE, 32'd0, 31'd0, 8'd0, 5'd1);
        // capacity lowered under the fill level: entries stay, fill cannot grow
        add_marker(JOB_CFG, 5'd2);
        add_cmd(CMD_INSERT, 32'hFFFF_FFFF, 31'd8, 8'd8, 5'd1);
        add_cmd(CMD_INSERT, 32'd7, 31'd9, 8'd9, 5'd1);
        // oversized remove clamps at empty
        add_cmd(CMD_REMOVE, 32'd0, 31'd0, 8'd0, 5'd31);
        add_cmd(CMD_INSERT, 32'd9, 31'd10, 8'd10, 5'd1);
        add_cmd(CMD_CLEAR, 32'd0, 31'd0, 8'd0, 5'd1);
        add_cmd(CMD_READ_HEAD, 32'd0, 31'd0, 8'd0, 5'd1);

        // random phases, each under its own capacity
        phase = 0;
        while (total_cmds < RANDOM_CMDS + 25) begin
            case (phase)
                0:       cap = 5'd16;
                1:       cap = 5'd1;
                2:       cap = 5'd4;
                3:       cap = 5'd0;
                4:       cap = 5'd31;
                5:       cap = 5'd8;
                default: cap = CAP_W'($urandom_range(0, 31));
            endcase
            add_marker(JOB_CFG, cap);
            burst = $urandom_range(40, 120);
            if (burst > RANDOM_CMDS + 25 - total_cmds) burst = RANDOM_CMDS + 25 - total_cmds;
            for (int i = 0; i < burst; i++) begin
                // hold the sender once until all results are back
                if (phase == 2 && i == burst / 2) add_marker(JOB_DRAIN, '0);
                add_random_cmd();
            end
            phase++;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_backlog.size() != 0 || s_axis_tvalid || sent_count != recv_count)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
